/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the intercept time checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that a property holds at every clock edge outside reset.
`define TTI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert that a condition never holds outside reset.
`define TTI_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* rtl/core/tti_pkg.sv */
// ----------------------------------------------------------------------------
// Intercept time package
// Widths, constants and codes shared by the intercept time pipeline.
// ----------------------------------------------------------------------------
package tti_pkg;

  // Gravity in ft/s^2, Q8
  localparam logic [13:0] GRAVITY_Q8 = 14'd8236;

  // Pipelined divider: dividend (and quotient) width, divisor width
  localparam int DIV_NW = 47;
  localparam int DIV_DW = 38;

  // Pipelined square root: radicand width and root width
  localparam int SQ_W  = 60;
  localparam int SQ_RW = SQ_W / 2;

  // Cycles from an accepted word to its result strobe
  localparam int PIPE_LAT = 9 + 2 * DIV_NW + SQ_RW;

  // Times in seconds, Q8
  localparam logic [11:0] T_15S   = 12'd3840;
  localparam logic [11:0] T_10S   = 12'd2560;
  localparam logic [7:0]  T_HALFS = 8'd128;

  // Saturation limits
  localparam logic [23:0] IMPACT_MAX  = 24'hFFFFFF;
  localparam logic [15:0] ROUNDED_MAX = 16'hFFFF;

  // HUD status codes
  localparam logic [1:0] HUD_NONE      = 2'd0;
  localparam logic [1:0] HUD_LOCKED    = 2'd1;
  localparam logic [1:0] HUD_IN_RANGE  = 2'd2;
  localparam logic [1:0] HUD_OUT_RANGE = 2'd3;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_THRUST = 2'd0,
    REG_DRAG   = 2'd1,
    REG_WEIGHT = 2'd2,
    REG_ARM    = 2'd3
  } cfg_reg_t;

  // Sideband carried alongside the first divider
  typedef struct packed {
    logic               ok;
    logic [19:0]        d;
    logic signed [12:0] r;
    logic               lock;
  } sb_div1_t;

  // Sideband carried alongside the square root
  typedef struct packed {
    logic               ok;
    logic [37:0]        a;
    logic signed [12:0] r;
    logic               lock;
  } sb_sqrt_t;

  // Sideband carried alongside the second divider
  typedef struct packed {
    logic ok;
    logic lock;
  } sb_div2_t;

endpackage

/* rtl/core/tti_div.sv */
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division, one quotient bit per stage, a new word every cycle.
// ----------------------------------------------------------------------------
module tti_div import tti_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic              out_valid,
  output logic [DIV_NW-1:0] quotient
);

  // Stage k holds partial remainder and the dividend shifting out while
  // quotient bits shift in at the bottom.
  logic [DIV_DW-1:0] rem_s [0:DIV_NW];
  logic [DIV_NW-1:0] num_s [0:DIV_NW];
  logic [DIV_DW-1:0] dsr_s [0:DIV_NW];
  logic              vld_s [0:DIV_NW];

  assign rem_s[0] = '0;
  assign num_s[0] = dividend;
  assign dsr_s[0] = divisor;
  assign vld_s[0] = in_valid;

  for (genvar k = 0; k < DIV_NW; k++) begin : g_stage
    logic [DIV_DW:0] trial;
    logic [DIV_DW:0] diff;
    logic            ge;

    always_comb begin
      trial = {rem_s[k], num_s[k][DIV_NW-1]};
      diff  = trial - {1'b0, dsr_s[k]};
      ge    = trial >= {1'b0, dsr_s[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else begin
        vld_s[k+1] <= vld_s[k];
      end
      rem_s[k+1] <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      num_s[k+1] <= {num_s[k][DIV_NW-2:0], ge};
      dsr_s[k+1] <= dsr_s[k];
    end
  end

  assign out_valid = vld_s[DIV_NW];
  assign quotient  = num_s[DIV_NW];

endmodule

/* rtl/core/tti_sqrt.sv */
// ----------------------------------------------------------------------------
// Pipelined square root
// Digit-by-digit floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tti_sqrt import tti_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [SQ_W-1:0]  radicand,
  output logic             out_valid,
  output logic [SQ_RW-1:0] root
);

  logic [SQ_RW+1:0] rem_s  [0:SQ_RW];
  logic [SQ_RW-1:0] root_s [0:SQ_RW];
  logic [SQ_W-1:0]  x_s    [0:SQ_RW];
  logic             vld_s  [0:SQ_RW];

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign x_s[0]    = radicand;
  assign vld_s[0]  = in_valid;

  for (genvar k = 0; k < SQ_RW; k++) begin : g_stage
    logic [SQ_RW+3:0] cat;
    logic [SQ_RW+3:0] trial;
    logic [SQ_RW+3:0] diff;
    logic             ge;

    always_comb begin
      cat   = {rem_s[k], x_s[k][SQ_W-1 -: 2]};
      trial = {2'b00, root_s[k], 2'b01};
      diff  = cat - trial;
      ge    = cat >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else begin
        vld_s[k+1] <= vld_s[k];
      end
      rem_s[k+1]  <= ge ? diff[SQ_RW+1:0] : cat[SQ_RW+1:0];
      root_s[k+1] <= {root_s[k][SQ_RW-2:0], ge};
      x_s[k+1]    <= {x_s[k][SQ_W-3:0], 2'b00};
    end
  end

  assign out_valid = vld_s[SQ_RW];
  assign root      = root_s[SQ_RW];

endmodule

/* rtl/core/missile_time_to_impact_advisory.sv */
// ----------------------------------------------------------------------------
// Missile time to impact advisory
// Net boost acceleration, intercept quadratic and HUD cue, fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | fields
//  ---------+------------------------+------------------------------------------
//  input    | start, busy            | own_speed .. seeker_lock
//  result   | done (one-cycle)       | time_valid, impact_time, rounded_seconds,
//           |                        | hud_status, shoot_cue
//  config   | cfg_we                 | cfg_index, cfg_data
//
//  A word is taken on every cycle that start is high and busy is low; busy
//  is high only during reset. Each result appears for one cycle on done. The
//  pipeline is made of the two 47-stage restoring dividers (acceleration and
//  time) and the 30-stage square root, plus nine stages of multiply, add and
//  select. Throughput is one word per cycle.
//  Reset clears all valid bits and loads the register defaults; nothing
//  stalls, as the receiver takes every result.
//
module missile_time_to_impact_advisory import tti_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // command
  input  logic               start,
  output logic               busy,
  input  logic [11:0]        own_speed,
  input  logic [15:0]        air_density,
  input  logic [19:0]        target_distance,
  input  logic signed [12:0] closure_rate,
  input  logic               radar_track_valid,
  input  logic               seeker_lock,
  // result
  output logic               done,
  output logic               time_valid,
  output logic [23:0]        impact_time,
  output logic [15:0]        rounded_seconds,
  output logic [1:0]         hud_status,
  output logic               shoot_cue,
  // configuration
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] max_thrust;
  logic [15:0] drag_coefficient;
  logic [15:0] launch_weight;
  logic [15:0] arming_delay;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_thrust       <= 16'd2500;
      drag_coefficient <= 16'd819;
      launch_weight    <= 16'd334;
      arming_delay     <= 16'd128;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_THRUST: max_thrust       <= cfg_data;
        REG_DRAG:   drag_coefficient <= cfg_data;
        REG_WEIGHT: launch_weight    <= cfg_data;
        REG_ARM:    arming_delay     <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Hold off input words only while reset is applied.
  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // Stage 1: speed squared and density times drag coefficient
  // --------------------------------------------------------------------------
  logic               v1;
  logic [23:0]        v2_1;
  logic [31:0]        rc_1;
  logic [19:0]        d_1;
  logic signed [12:0] r_1;
  logic               track_1, lock_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    v2_1    <= 24'(own_speed) * 24'(own_speed);
    rc_1    <= 32'(air_density) * 32'(drag_coefficient);
    d_1     <= target_distance;
    r_1     <= closure_rate;
    track_1 <= radar_track_valid;
    lock_1  <= seeker_lock;
  end

  // --------------------------------------------------------------------------
  // Stage 2: drag force, Q16 lbf
  // --------------------------------------------------------------------------
  logic               v2;
  logic [55:0]        drag_full;
  logic [34:0]        drag_2;
  logic [19:0]        d_2;
  logic signed [12:0] r_2;
  logic               track_2, lock_2;

  assign drag_full = 56'(rc_1) * 56'(v2_1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    drag_2  <= drag_full[55:21];
    d_2     <= d_1;
    r_2     <= r_1;
    track_2 <= track_1;
    lock_2  <= lock_1;
  end

  // --------------------------------------------------------------------------
  // Stage 3: net force; no solution without a track or when drag reaches thrust
  // --------------------------------------------------------------------------
  logic               v3;
  logic [34:0]        thrust_q16;
  logic [31:0]        net_3;
  logic               ok_3;
  logic [19:0]        d_3;
  logic signed [12:0] r_3;
  logic               lock_3;

  assign thrust_q16 = {3'b000, max_thrust, 16'h0000};

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    ok_3   <= track_2 && (drag_2 < thrust_q16);
    net_3  <= 32'(thrust_q16 - drag_2);
    d_3    <= d_2;
    r_3    <= r_2;
    lock_3 <= lock_2;
  end

  // --------------------------------------------------------------------------
  // Stage 4: net force times gravity
  // --------------------------------------------------------------------------
  logic               v4;
  logic [45:0]        prod_4;
  sb_div1_t           sb_4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    prod_4 <= 46'(net_3) * 46'(GRAVITY_Q8);
    sb_4   <= '{ok: ok_3, d: d_3, r: r_3, lock: lock_3};
  end

  // --------------------------------------------------------------------------
  // Acceleration divide: floor(prod / 256 / weight), weight zero taken as one
  // --------------------------------------------------------------------------
  logic [15:0]       weight;
  logic              div1_vld;
  logic [DIV_NW-1:0] div1_q;
  sb_div1_t          sb1_d [DIV_NW];

  assign weight = (launch_weight == 16'd0) ? 16'd1 : launch_weight;

  tti_div u_div_accel (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .dividend  (DIV_NW'(prod_4[45:8])),
    .divisor   (DIV_DW'(weight)),
    .out_valid (div1_vld),
    .quotient  (div1_q)
  );

  always_ff @(posedge clk) begin
    sb1_d[0] <= sb_4;
    for (int i = 1; i < DIV_NW; i++) begin
      sb1_d[i] <= sb1_d[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: acceleration, Q16 ft/s^2; drop a zero acceleration
  // --------------------------------------------------------------------------
  logic               v5;
  logic [37:0]        a_5;
  logic               ok_5;
  logic [19:0]        d_5;
  logic signed [12:0] r_5;
  logic               lock_5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= div1_vld;
    end
    a_5    <= div1_q[37:0];
    ok_5   <= sb1_d[DIV_NW-1].ok && (div1_q[37:0] != 38'd0);
    d_5    <= sb1_d[DIV_NW-1].d;
    r_5    <= sb1_d[DIV_NW-1].r;
    lock_5 <= sb1_d[DIV_NW-1].lock;
  end

  // --------------------------------------------------------------------------
  // Stage 6: a*d in two partial products, closure rate squared
  // --------------------------------------------------------------------------
  logic               v6;
  logic [12:0]        rr;
  logic [51:0]        pl_6;
  logic [25:0]        ph_6;
  logic [25:0]        rr2_6;
  logic [37:0]        a_6;
  logic               ok_6;
  logic signed [12:0] r_6;
  logic               lock_6;

  assign rr = r_5[12] ? 13'(-r_5) : 13'(r_5);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    pl_6   <= 52'(a_5[31:0]) * 52'(d_5);
    ph_6   <= 26'(a_5[37:32]) * 26'(d_5);
    rr2_6  <= 26'(rr) * 26'(rr);
    a_6    <= a_5;
    ok_6   <= ok_5;
    r_6    <= r_5;
    lock_6 <= lock_5;
  end

  // --------------------------------------------------------------------------
  // Stage 7: discriminant r^2*2^16 + 2*a*d; drop a zero discriminant
  // --------------------------------------------------------------------------
  logic               v7;
  logic [SQ_W-1:0]    disc;
  logic [SQ_W-1:0]    n_7;
  sb_sqrt_t           sb_7;

  assign disc = (SQ_W'(rr2_6) << 16) + (SQ_W'(ph_6) << 33) + (SQ_W'(pl_6) << 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    n_7  <= disc;
    sb_7 <= '{ok: ok_6 && (disc != '0), a: a_6, r: r_6, lock: lock_6};
  end

  // --------------------------------------------------------------------------
  // Square root of the discriminant, Q8 ft/s
  // --------------------------------------------------------------------------
  logic             sq_vld;
  logic [SQ_RW-1:0] sq_root;
  sb_sqrt_t         sb2_d [SQ_RW];

  tti_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7),
    .radicand  (n_7),
    .out_valid (sq_vld),
    .root      (sq_root)
  );

  always_ff @(posedge clk) begin
    sb2_d[0] <= sb_7;
    for (int i = 1; i < SQ_RW; i++) begin
      sb2_d[i] <= sb2_d[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: pick the smallest non-negative root numerator
  // --------------------------------------------------------------------------
  logic               v8;
  logic signed [32:0] rq8, sx, n1, n2;
  logic [30:0]        num_8;
  logic [37:0]        a_8;
  sb_div2_t           sb_8;

  always_comb begin
    rq8 = {{12{sb2_d[SQ_RW-1].r[12]}}, sb2_d[SQ_RW-1].r, 8'h00};
    sx  = {3'b000, sq_root};
    n2  = -rq8 - sx;
    n1  = sx - rq8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= sq_vld;
    end
    num_8 <= !n2[32] ? n2[30:0] : n1[30:0];
    a_8   <= sb2_d[SQ_RW-1].a;
    sb_8  <= '{ok: sb2_d[SQ_RW-1].ok && (!n2[32] || !n1[32]),
               lock: sb2_d[SQ_RW-1].lock};
  end

  // --------------------------------------------------------------------------
  // Time divide: floor(num * 2^16 / a), Q8 seconds
  // --------------------------------------------------------------------------
  logic              div2_vld;
  logic [DIV_NW-1:0] t_full;
  sb_div2_t          sb3_d [DIV_NW];

  tti_div u_div_time (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v8),
    .dividend  ({num_8, 16'h0000}),
    .divisor   (a_8),
    .out_valid (div2_vld),
    .quotient  (t_full)
  );

  always_ff @(posedge clk) begin
    sb3_d[0] <= sb_8;
    for (int i = 1; i < DIV_NW; i++) begin
      sb3_d[i] <= sb3_d[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: saturate, round, status and shot cue into the result register
  // --------------------------------------------------------------------------
  logic        ok_f, lock_f;
  logic        t_le15, t_le10, t_armed;
  logic [DIV_NW:0] t_round;
  logic [1:0]  status;

  always_comb begin
    ok_f    = sb3_d[DIV_NW-1].ok;
    lock_f  = sb3_d[DIV_NW-1].lock;
    t_le15  = t_full <= DIV_NW'(T_15S);
    t_le10  = t_full <= DIV_NW'(T_10S);
    t_armed = t_full > (DIV_NW'(arming_delay) + DIV_NW'(T_HALFS));
    t_round = ((DIV_NW+1)'(t_full) + (DIV_NW+1)'(T_HALFS)) >> 8;
    if (lock_f && (!ok_f || t_le15)) begin
      status = HUD_LOCKED;
    end else if (!ok_f) begin
      status = HUD_NONE;
    end else if (t_le15) begin
      status = HUD_IN_RANGE;
    end else begin
      status = HUD_OUT_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div2_vld;
    end
    time_valid <= ok_f;
    if (!ok_f) begin
      impact_time     <= '0;
      rounded_seconds <= '0;
    end else begin
      impact_time     <= (t_full > DIV_NW'(IMPACT_MAX)) ? IMPACT_MAX : t_full[23:0];
      rounded_seconds <= (t_round > (DIV_NW+1)'(ROUNDED_MAX)) ? ROUNDED_MAX
                                                               : t_round[15:0];
    end
    hud_status <= status;
    shoot_cue  <= lock_f && ok_f && t_le10 && t_armed;
  end

endmodule

/* rtl/core/tti_checker.sv */
// ----------------------------------------------------------------------------
// Intercept time checker
// Port-level checks on result timing and consistency of the result word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tti_checker import tti_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               time_valid,
  input logic [23:0]        impact_time,
  input logic [15:0]        rounded_seconds,
  input logic [1:0]         hud_status,
  input logic               shoot_cue
);

  logic zero_times;
  logic range_status;

  assign zero_times   = (impact_time == 24'd0) && (rounded_seconds == 16'd0);
  assign range_status = (hud_status == HUD_IN_RANGE) || (hud_status == HUD_OUT_RANGE);

  // every accepted word yields its result after the fixed latency
  `TTI_ASSERT(a_latency, clk, rst, start && !busy |-> ##PIPE_LAT done, "result strobe missing")
  // a word without a solution carries zero times
  `TTI_ASSERT(a_zero_time, clk, rst, done && !time_valid |-> zero_times, "time without solution")
  // a shot cue needs a solution inside the locked window
  `TTI_ASSERT(a_shoot, clk, rst, done && shoot_cue |-> time_valid && hud_status == HUD_LOCKED,
              "shot cue unlocked")
  // no solution never reports a range status
  `TTI_NEVER(a_status, clk, rst, done && !time_valid && range_status, "range status, no solution")

endmodule

bind missile_time_to_impact_advisory tti_checker u_tti_checker (.*);

/* tb/sv/missile_time_to_impact_advisory_checker.sv */
// ----------------------------------------------------------------------------
// Intercept advisory checker
// Watches the command, result and register ports and predicts every result.
// It compares each result field by field and counts mismatches.
// ----------------------------------------------------------------------------
module missile_time_to_impact_advisory_checker import tti_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [11:0]        own_speed,
  input  logic [15:0]        air_density,
  input  logic [19:0]        target_distance,
  input  logic signed [12:0] closure_rate,
  input  logic               radar_track_valid,
  input  logic               seeker_lock,
  input  logic               done,
  input  logic               time_valid,
  input  logic [23:0]        impact_time,
  input  logic [15:0]        rounded_seconds,
  input  logic [1:0]         hud_status,
  input  logic               shoot_cue,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 mismatches,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        valid;
    logic [23:0] impact;
    logic [15:0] rounded;
    logic [1:0]  hud;
    logic        shoot;
  } advisory_t;

  logic [15:0] thrust_lbf, drag_cd, weight_lb, arm_delay;
  advisory_t   advisory_q[$];

  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] root, trial;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic advisory_t predict_advisory(
    input logic [11:0] v, input logic [15:0] rho, input logic [19:0] d,
    input logic signed [12:0] r, input logic track, input logic lock);
    logic [63:0] drag, thrust, net, w, accel, rmag, n, s, num, t;
    longint      rq8, n1, n2;
    logic        ok;
    advisory_t   res;
    ok = 1'b0;
    t  = 0;
    res = '0;
    drag   = (64'(rho) * 64'(drag_cd) * (64'(v) * 64'(v))) >> 21;
    thrust = 64'(thrust_lbf) << 16;
    if (track && drag < thrust) begin
      net   = thrust - drag;
      w     = (weight_lb == 0) ? 64'd1 : 64'(weight_lb);
      accel = (net * 64'(GRAVITY_Q8)) / (w * 256);
      rmag  = (r < 0) ? 64'(-longint'(r)) : 64'(r);
      n     = ((rmag * rmag) << 16) + 2 * accel * 64'(d);
      if (accel != 0 && n != 0) begin
        s   = floor_root(n);
        rq8 = longint'(r) * 256;
        n2  = -rq8 - longint'(s);
        n1  = longint'(s) - rq8;
        // take the smaller root when it is not negative
        if (n2 >= 0) begin
          num = 64'(n2);
          ok  = 1'b1;
        end else if (n1 >= 0) begin
          num = 64'(n1);
          ok  = 1'b1;
        end
        if (ok) t = (num << 16) / accel;
      end
    end
    res.valid = ok;
    if (ok) begin
      res.impact  = (t > 64'(IMPACT_MAX)) ? IMPACT_MAX : t[23:0];
      res.rounded = (((t + 128) >> 8) > 64'(ROUNDED_MAX)) ? ROUNDED_MAX
                                                           : 16'((t + 128) >> 8);
    end
    if (lock && (!ok || t <= 64'(T_15S))) res.hud = HUD_LOCKED;
    else if (!ok)                         res.hud = HUD_NONE;
    else if (t <= 64'(T_15S))             res.hud = HUD_IN_RANGE;
    else                                  res.hud = HUD_OUT_RANGE;
    res.shoot = lock && ok && t <= 64'(T_10S)
                && t > 64'(arm_delay) + 64'(T_HALFS);
    return res;
  endfunction

  always @(posedge clk) begin
    advisory_t seen, want;
    if (rst) begin
      thrust_lbf <= 16'd2500;
      drag_cd    <= 16'd819;
      weight_lb  <= 16'd334;
      arm_delay  <= 16'd128;
      advisory_q.delete();
      mismatches <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_THRUST: thrust_lbf <= cfg_data;
          REG_DRAG:   drag_cd    <= cfg_data;
          REG_WEIGHT: weight_lb  <= cfg_data;
          REG_ARM:    arm_delay  <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy)
        advisory_q.push_back(predict_advisory(own_speed, air_density, target_distance,
                                              closure_rate, radar_track_valid,
                                              seeker_lock));
      if (done) begin
        seen = '{time_valid, impact_time, rounded_seconds, hud_status, shoot_cue};
        if (advisory_q.size() == 0) begin
          if (mismatches < 10) $display("ERROR: result word with nothing expected");
          mismatches <= mismatches + 1;
        end else begin
          want = advisory_q.pop_front();
          if (seen !== want) begin
            if (mismatches < 10)
              $display({"ERROR: valid %0d/%0d impact %h/%h rounded %0d/%0d ",
                        "hud %0d/%0d shoot %0d/%0d (exp/act)"},
                       want.valid, seen.valid, want.impact, seen.impact,
                       want.rounded, seen.rounded, want.hud, seen.hud,
                       want.shoot, seen.shoot);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    pending <= advisory_q.size();
  end

endmodule

/* tb/sv/missile_time_to_impact_advisory_tb.sv */
// ----------------------------------------------------------------------------
// Intercept advisory testbench
// Drives directed and random words through several register settings, with
// sender gaps, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module missile_time_to_impact_advisory_tb;
  import tti_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int WORDS_PER_SETTING = 165;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [11:0]        own_speed = '0;
  logic [15:0]        air_density = '0;
  logic [19:0]        target_distance = '0;
  logic signed [12:0] closure_rate = '0;
  logic               radar_track_valid = 1'b0;
  logic               seeker_lock = 1'b0;
  logic               done, time_valid, shoot_cue;
  logic [23:0]        impact_time;
  logic [15:0]        rounded_seconds;
  logic [1:0]         hud_status;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  int                 mismatches, pending;
  int                 cycles = 0;
  int                 gap_pct = 38;

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  missile_time_to_impact_advisory u_top (.*);

  missile_time_to_impact_advisory_checker u_checker (.*);

  // Watchdog: end the run if the pipeline stops delivering
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one word; hold it until busy is seen low ahead of a rising edge.
  // Idle first, with each idle cycle drawn at the current sender idle rate.
  task automatic send_word(input logic [11:0] v, input logic [15:0] rho,
                           input logic [19:0] d, input logic [12:0] r,
                           input logic track, input logic lock);
    logic held;
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk) start <= 1'b0;
    end
    @(negedge clk);
    start             <= 1'b1;
    own_speed         <= v;
    air_density       <= rho;
    target_distance   <= d;
    closure_rate      <= r;
    radar_track_valid <= track;
    seeker_lock       <= lock;
    forever begin
      held = busy;
      @(posedge clk);
      if (!held) break;
      @(negedge clk);
    end
  endtask

  task automatic send_random_word();
    logic [15:0] rho;
    logic [19:0] d;
    // keep most densities and ranges near a realistic envelope
    rho = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(50000));
    d   = ($urandom_range(2) == 0) ? 20'($urandom) : 20'($urandom_range(30000));
    send_word(12'($urandom), rho, d, 13'($urandom), $urandom_range(9) != 0,
              1'($urandom));
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  // Registers are only touched with the pipeline empty
  task automatic load_setting(input logic [15:0] thr, input logic [15:0] cd,
                              input logic [15:0] wt, input logic [15:0] arm);
    @(negedge clk) start <= 1'b0;
    wait (pending == 0);
    repeat (PIPE_LAT + 4) @(posedge clk);
    write_reg(REG_THRUST, thr);
    write_reg(REG_DRAG, cd);
    write_reg(REG_WEIGHT, wt);
    write_reg(REG_ARM, arm);
  endtask

  logic [15:0] setting [7][4] = '{
    '{16'd2500,  16'd819,   16'd334,   16'd128},
    '{16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF},
    '{16'd0,     16'd0,     16'd1,     16'd0},
    '{16'hFFFF,  16'd0,     16'd0,     16'd0},
    '{16'd1,     16'hFFFF,  16'd1,     16'hFFFF},
    '{16'd9000,  16'd300,   16'd200,   16'd600},
    '{16'd2500,  16'd819,   16'd334,   16'd128}
  };

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    wait (!busy);

    // Directed: field extremes and each special case, reset registers
    send_word(12'd0, 16'd0, 20'd0, 13'd0, 1'b1, 1'b0);             // zero discriminant
    send_word(12'd0, 16'd0, 20'd0, 13'd0, 1'b1, 1'b1);             // locked, no solution
    send_word(12'd500, 16'd40000, 20'd8000, 13'd300, 1'b0, 1'b1);  // no track
    send_word(12'd4095, 16'hFFFF, 20'd5000, 13'd200, 1'b1, 1'b1);  // drag beats thrust
    send_word(12'd0, 16'd0, 20'd0, 13'd100, 1'b1, 1'b1);           // closing, zero range
    send_word(12'd0, 16'd0, 20'd0, -13'sd100, 1'b1, 1'b1);         // opening, zero range
    send_word(12'd0, 16'd0, 20'hFFFFF, -13'sd4096, 1'b1, 1'b0);    // long time
    send_word(12'd0, 16'd0, 20'hFFFFF, 13'sd4095, 1'b1, 1'b1);
    send_word(12'd4095, 16'd0, 20'd0, 13'sd4095, 1'b1, 1'b0);
    send_word(12'd800, 16'd38000, 20'd6000, 13'd400, 1'b1, 1'b1);  // in range, cue
    send_word(12'd800, 16'd38000, 20'd12000, 13'd400, 1'b1, 1'b1); // near 10 s
    send_word(12'd800, 16'd38000, 20'd25000, 13'd400, 1'b1, 1'b0); // near 15 s
    send_word(12'd800, 16'd38000, 20'd60000, 13'd100, 1'b1, 1'b0); // out of range
    send_word(12'd800, 16'd38000, 20'd60000, 13'd100, 1'b1, 1'b1);
    send_word(12'd800, 16'd38000, 20'd100, 13'd1000, 1'b1, 1'b1);  // inside arming delay
    send_word(12'd4095, 16'hFFFF, 20'hFFFFF, -13'sd4096, 1'b0, 1'b0);
    send_word(12'd300, 16'd1000, 20'd3000, -13'sd2000, 1'b1, 1'b1);

    // Random words across register settings; sender gap rate rises, then drops to zero
    for (int k = 0; k < 7; k++) begin
      if (k == 2) gap_pct = 52;
      if (k == 5) gap_pct = 0;
      load_setting(setting[k][0], setting[k][1], setting[k][2], setting[k][3]);
      repeat (WORDS_PER_SETTING) send_random_word();
    end
    @(negedge clk) start <= 1'b0;

    // Drain the pipeline, then allow for any stray strobe
    wait (pending == 0);
    repeat (PIPE_LAT + 8) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/tti_pkg.sv
rtl/core/tti_div.sv
rtl/core/tti_sqrt.sv
rtl/core/missile_time_to_impact_advisory.sv
rtl/core/tti_checker.sv
tb/sv/missile_time_to_impact_advisory_checker.sv
tb/sv/missile_time_to_impact_advisory_tb.sv
